FILE: sv/ucpf_pkg.sv
// Package for the UDP command packet filter: constants, codes and the result type.
package ucpf_pkg;

    // Size of the command carried in a command datagram
    localparam int COMMAND_BYTES = 16;

    // Ethertypes and protocol
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Byte offsets within the frame
    localparam logic [6:0] POS_ETYPE_HI   = 7'd12;
    localparam logic [6:0] POS_ETYPE_LO   = 7'd13;
    localparam logic [6:0] POS_V4_PROTO   = 7'd23;
    localparam logic [6:0] POS_V6_NEXT    = 7'd20;
    localparam logic [6:0] L4_START_V4    = 7'd34;
    localparam logic [6:0] L4_START_V6    = 7'd54;
    localparam logic [6:0] UDP_HDR_LEN    = 7'd8;
    localparam logic [6:0] POSITION_MAX   = 7'd127;

    // Network kind codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_IPV6 = 2'd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_PASS    = 2'd0;
    localparam logic [1:0] VERDICT_DROP    = 2'd1;
    localparam logic [1:0] VERDICT_ABORTED = 2'd2;
    localparam logic [1:0] VERDICT_UNUSED  = 2'd3;

    // Register addresses (byte address bit 2 selects the register)
    localparam logic ADDR_COMMAND_PORT = 1'b0;
    localparam logic ADDR_SLOT_PRESENT = 1'b1;

    // Result of one frame
    typedef struct packed {
        logic [63:0] second_half;
        logic [63:0] first_half;
        logic        written;
        logic [1:0]  verdict;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

FILE: sv/udp_command_packet_filter_unit.sv
// Top level of the UDP command packet filter: stream ports, register port, result buffer.
//
//  channel   dir  transfer when           payload
//  s_*       in   s_tvalid & s_tready     s_tdata = frame_byte, s_tlast = end_of_frame
//  m_*       out  m_tvalid & m_tready     m_tdata = verdict, written, first/second half
//  APB       in   psel&penable&pwrite     reg 0 command_port @0x0, reg 1 slot_present @0x4
//
// One byte is taken per cycle while s_tready is high; the verdict for a frame is
// registered as its last byte is taken, in the skid register if the output one is held.
// A two-entry result buffer (output register plus skid register) decouples the sides:
// s_tready drops only when both entries hold results not yet taken.
// Synchronous active-low reset clears the frame state, the command store, the
// registers (command_port 0, slot_present 1) and the result buffer.
module udp_command_packet_filter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Frame bytes in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] frame_byte
    input  logic                            s_tlast,
    // Verdicts out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] verdict, [2] command_written, [66:3] command_first_half,
    // [130:67] command_second_half, rest zero
    output logic [ucpf_pkg::TDATA_W-1:0]    m_tdata,
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [15:0]        r_command_port;
    logic               r_slot_present;
    logic               accept;
    logic               cfg_write;
    ucpf_pkg::t_result  result;

    logic               r_out_v, n_out_v;
    logic               r_skid_v, n_skid_v;
    ucpf_pkg::t_result  r_out, n_out;
    ucpf_pkg::t_result  r_skid, n_skid;
    logic               push;
    logic               pop;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            ucpf_pkg::ADDR_COMMAND_PORT: prdata = {16'h0000, r_command_port};
            ucpf_pkg::ADDR_SLOT_PRESENT: prdata = {31'h0, r_slot_present};
            default:                     prdata = 32'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_port <= 16'h0000;
            r_slot_present <= 1'b1;
        end else if (cfg_write) begin
            case (paddr[2])
                ucpf_pkg::ADDR_COMMAND_PORT: r_command_port <= pwdata[15:0];
                ucpf_pkg::ADDR_SLOT_PRESENT: r_slot_present <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Input transfer
    assign s_tready = !r_skid_v;
    assign accept   = s_tvalid && s_tready;

    ucpf_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_frame_byte   (s_tdata),
        .i_end_of_frame (s_tlast),
        .i_command_port (r_command_port),
        .i_slot_present (r_slot_present),
        .o_result       (result)
    );

    // Result buffer: output register with a skid entry behind it
    assign push = accept && s_tlast;
    assign pop  = r_out_v && m_tready;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                n_out_v  = 1'b1;
                n_out    = r_skid;
                n_skid_v = push;
                n_skid   = result;
            end else begin
                n_out_v  = push;
                n_out    = result;
            end
        end else if (push) begin
            n_skid_v = 1'b1;
            n_skid   = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = {{(ucpf_pkg::TDATA_W - ucpf_pkg::RESULT_W){1'b0}}, r_out};

    // The skid entry is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid with empty output register");

    // No reserved verdict code leaves the block
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.verdict != ucpf_pkg::VERDICT_UNUSED))
        else $error("reserved verdict code on output");

    // A command write always comes with a pass verdict
    a_written_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.written) |-> (r_out.verdict == ucpf_pkg::VERDICT_PASS))
        else $error("command written without pass verdict");

    // A frame end arriving while the output waits lands in the skid entry
    a_push_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_out_v && !m_tready) |=> r_skid_v)
        else $error("result lost while output register stalled");

endmodule

FILE: sv/ucpf_parser.sv
// Frame parser: per-frame header state, capture buffer, command store and verdict.
module ucpf_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_frame_byte,
    input  logic                    i_end_of_frame,
    input  logic [15:0]             i_command_port,
    input  logic                    i_slot_present,
    output ucpf_pkg::t_result       o_result
);

    localparam int CB = ucpf_pkg::COMMAND_BYTES;

    // Per-frame state
    logic [6:0]  r_pos,   n_pos;
    logic [15:0] r_etype, n_etype;
    logic [7:0]  r_proto, n_proto;
    logic [1:0]  r_kind,  n_kind;
    logic [15:0] r_port,  n_port;
    logic [7:0]  r_cap   [CB];
    logic [7:0]  n_cap   [CB];
    logic [7:0]  r_store [CB];
    logic [7:0]  n_store [CB];

    logic        take;
    logic [6:0]  l4;
    logic [6:0]  cap_base;
    logic [7:0]  len;
    logic [7:0]  l4_len;
    logic [1:0]  verdict;
    logic        written;

    // Header and payload capture for the current byte
    always_comb begin
        take     = (r_pos != ucpf_pkg::POSITION_MAX);
        n_pos    = take ? r_pos + 7'd1 : r_pos;
        n_etype  = r_etype;
        n_kind   = r_kind;
        n_proto  = r_proto;
        n_port   = r_port;
        n_cap    = r_cap;
        l4       = (r_kind == ucpf_pkg::KIND_IPV4) ? ucpf_pkg::L4_START_V4
                                                   : ucpf_pkg::L4_START_V6;
        cap_base = l4 + ucpf_pkg::UDP_HDR_LEN;
        if (take) begin
            if (r_pos == ucpf_pkg::POS_ETYPE_HI) begin
                n_etype = {i_frame_byte, 8'h00};
            end else if (r_pos == ucpf_pkg::POS_ETYPE_LO) begin
                n_etype = {r_etype[15:8], i_frame_byte};
                if (n_etype == ucpf_pkg::ETHERTYPE_IPV4) begin
                    n_kind = ucpf_pkg::KIND_IPV4;
                end else if (n_etype == ucpf_pkg::ETHERTYPE_IPV6) begin
                    n_kind = ucpf_pkg::KIND_IPV6;
                end else begin
                    n_kind = ucpf_pkg::KIND_NONE;
                end
            end
            // Offsets past the ethertype only count for IPv4/IPv6 frames
            if (r_kind != ucpf_pkg::KIND_NONE) begin
                if ((r_kind == ucpf_pkg::KIND_IPV4 && r_pos == ucpf_pkg::POS_V4_PROTO) ||
                    (r_kind == ucpf_pkg::KIND_IPV6 && r_pos == ucpf_pkg::POS_V6_NEXT)) begin
                    n_proto = i_frame_byte;
                end
                if (r_pos == l4 + 7'd2) begin
                    n_port = {i_frame_byte, 8'h00};
                end else if (r_pos == l4 + 7'd3) begin
                    n_port = {r_port[15:8], i_frame_byte};
                end
                for (int k = 0; k < CB; k++) begin
                    if (r_pos == cap_base + 7'(k)) begin
                        n_cap[k] = i_frame_byte;
                    end
                end
            end
        end
    end

    // Verdict on the final byte, from the state after this byte
    always_comb begin
        len     = {1'b0, r_pos} + 8'd1;
        l4_len  = (n_kind == ucpf_pkg::KIND_IPV4) ? {1'b0, ucpf_pkg::L4_START_V4}
                                                  : {1'b0, ucpf_pkg::L4_START_V6};
        verdict = ucpf_pkg::VERDICT_PASS;
        written = 1'b0;
        if (n_kind == ucpf_pkg::KIND_NONE) begin
            verdict = ucpf_pkg::VERDICT_PASS;
        end else if (len < l4_len) begin
            verdict = ucpf_pkg::VERDICT_ABORTED;
        end else if (n_proto != ucpf_pkg::PROTO_UDP) begin
            verdict = ucpf_pkg::VERDICT_PASS;
        end else if (len < l4_len + {1'b0, ucpf_pkg::UDP_HDR_LEN}) begin
            verdict = ucpf_pkg::VERDICT_ABORTED;
        end else if ({1'b0, n_port} == {1'b0, i_command_port} + 17'd1) begin
            verdict = ucpf_pkg::VERDICT_DROP;
        end else if (n_port != i_command_port) begin
            verdict = ucpf_pkg::VERDICT_PASS;
        end else if (len < l4_len + {1'b0, ucpf_pkg::UDP_HDR_LEN} + 8'(CB)) begin
            verdict = ucpf_pkg::VERDICT_ABORTED;
        end else if (i_slot_present) begin
            written = 1'b1;
        end
        if (written) begin
            n_store = n_cap;
        end else begin
            n_store = r_store;
        end
    end

    // Output halves of the store after this frame's update
    assign o_result.verdict = verdict;
    assign o_result.written = written;
    for (genvar k = 0; k < 8; k++) begin : g_half
        if (k < CB) begin : g_first
            assign o_result.first_half[63-8*k -: 8] = n_store[k];
        end else begin : g_first_zero
            assign o_result.first_half[63-8*k -: 8] = 8'h00;
        end
        if (k + 8 < CB) begin : g_second
            assign o_result.second_half[63-8*k -: 8] = n_store[k+8];
        end else begin : g_second_zero
            assign o_result.second_half[63-8*k -: 8] = 8'h00;
        end
    end

    // Per-frame state, cleared at the end of each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_proto <= '0;
            r_kind  <= ucpf_pkg::KIND_NONE;
            r_port  <= '0;
        end else if (i_accept) begin
            if (i_end_of_frame) begin
                r_pos   <= '0;
                r_etype <= '0;
                r_proto <= '0;
                r_kind  <= ucpf_pkg::KIND_NONE;
                r_port  <= '0;
            end else begin
                r_pos   <= n_pos;
                r_etype <= n_etype;
                r_proto <= n_proto;
                r_kind  <= n_kind;
                r_port  <= n_port;
            end
        end
    end

    // Capture buffer: every entry read is written in the same frame, by its final byte at the latest
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cap <= n_cap;
        end
    end

    // Stored command, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CB; k++) begin
                r_store[k] <= 8'h00;
            end
        end else if (i_accept && i_end_of_frame && written) begin
            r_store <= n_store;
        end
    end

endmodule
